// File: src/mlfq_pkg.sv
package mlfq_pkg;

    localparam int ID_W        = 22;
    localparam int SLICE_W     = 24;
    localparam int STATUS_W    = 3;
    localparam int LEVEL_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_LEVELS  = 4;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_ADMITTED   = 3'd0;
    localparam status_t ST_REFUSED    = 3'd1;
    localparam status_t ST_DISPATCHED = 3'd2;
    localparam status_t ST_DROPPED    = 3'd3;
    localparam status_t ST_IDLE       = 3'd4;

    localparam level_t LVL_REALTIME = 2'd0;
    localparam level_t LVL_ONE      = 2'd1;
    localparam level_t LVL_TWO      = 2'd2;
    localparam level_t LVL_THREE    = 2'd3;

    localparam logic CMD_ADMIT = 1'b0;
    localparam logic CMD_SLICE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_REALTIME    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_LEVEL_THREE = 3'd3;

    localparam logic [SLICE_W-1:0] SLICE_REALTIME_RESET    = 24'd2000000;
    localparam logic [SLICE_W-1:0] SLICE_LEVEL_ONE_RESET   = 24'd4000000;
    localparam logic [SLICE_W-1:0] SLICE_LEVEL_TWO_RESET   = 24'd8000000;
    localparam logic [SLICE_W-1:0] SLICE_LEVEL_THREE_RESET = 24'd16000000;

    // Decision taken for one item from the queue counts.
    typedef struct packed {
        status_t status;
        level_t  level;
        logic    pop;
        logic    push;
        level_t  push_level;
    } sched_dec_t;

endpackage

// File: src/mlfq_ram.sv
module mlfq_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/mlfq_ctrl.sv
module mlfq_ctrl import mlfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    localparam int PtrW = $clog2(QUEUE_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            command,
    input  logic            realtime_class,
    input  logic            finished,
    output sched_dec_t      dec,
    output logic [PtrW-1:0] rd_addr,
    output logic [PtrW-1:0] wr_addr
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int SumW = CntW + 1;
    localparam logic [SumW-1:0] DepthSum  = SumW'(QUEUE_DEPTH);
    localparam logic [CntW-1:0] DepthCnt  = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr   = PtrW'(QUEUE_DEPTH - 1);

    logic [PtrW-1:0] head_reg  [NUM_LEVELS];
    logic [PtrW-1:0] head_next [NUM_LEVELS];
    logic [CntW-1:0] count_reg  [NUM_LEVELS];
    logic [CntW-1:0] count_next [NUM_LEVELS];
    logic [SumW-1:0] tail_sum [NUM_LEVELS];
    logic [PtrW-1:0] tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] full;
    logic [NUM_LEVELS-1:0] occupied;
    level_t admit_level;
    level_t target_level;

    // The tail slot is the head plus the count, wrapped once.
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            tail_sum[i] = SumW'(head_reg[i]) + SumW'(count_reg[i]);
            if (tail_sum[i] >= DepthSum)
            begin
                tail[i] = PtrW'(tail_sum[i] - DepthSum);
            end
            else
            begin
                tail[i] = PtrW'(tail_sum[i]);
            end
            full[i]     = (count_reg[i] == DepthCnt);
            occupied[i] = (count_reg[i] != '0);
        end
    end

    always_comb
    begin
        dec          = '0;
        admit_level  = realtime_class ? LVL_REALTIME : LVL_ONE;
        target_level = LVL_REALTIME;
        if (command == CMD_ADMIT)
        begin
            if (full[admit_level])
            begin
                dec.status = ST_REFUSED;
            end
            else
            begin
                dec.status     = ST_ADMITTED;
                dec.push       = 1'b1;
                dec.push_level = admit_level;
            end
        end
        else
        begin
            dec.pop    = 1'b1;
            dec.status = ST_DISPATCHED;
            priority if (occupied[LVL_REALTIME])
            begin
                dec.level = LVL_REALTIME;
            end
            else if (occupied[LVL_ONE])
            begin
                dec.level = LVL_ONE;
            end
            else if (occupied[LVL_TWO])
            begin
                dec.level = LVL_TWO;
            end
            else if (occupied[LVL_THREE])
            begin
                dec.level = LVL_THREE;
            end
            else
            begin
                dec.pop    = 1'b0;
                dec.status = ST_IDLE;
            end

            unique case (dec.level)
                LVL_REALTIME: target_level = LVL_REALTIME;
                LVL_ONE:      target_level = LVL_TWO;
                default:      target_level = LVL_THREE;
            endcase

            // A task requeued onto its own level takes the slot its pop freed.
            if (dec.pop && !finished)
            begin
                if (target_level != dec.level && full[target_level])
                begin
                    dec.status = ST_DROPPED;
                end
                else
                begin
                    dec.push       = 1'b1;
                    dec.push_level = target_level;
                end
            end
        end
    end

    assign rd_addr = head_reg[dec.level];
    assign wr_addr = tail[dec.push_level];

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
            if (accept)
            begin
                if (dec.pop && dec.level == level_t'(i))
                begin
                    head_next[i] = (head_reg[i] == LastPtr) ? '0 : head_reg[i] + 1'b1;
                end
                if (dec.push && dec.push_level == level_t'(i)
                    && !(dec.pop && dec.level == level_t'(i)))
                begin
                    count_next[i] = count_reg[i] + 1'b1;
                end
                else if (dec.pop && dec.level == level_t'(i)
                         && !(dec.push && dec.push_level == level_t'(i)))
                begin
                    count_next[i] = count_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// File: src/multilevel_feedback_queue_scheduler.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid/cmd_ready    command, task_id, realtime_class, finished
// rsp       out        rsp_valid/rsp_ready    status, dispatched_id, dispatched_level,
//                                             slice_length
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One command is accepted per cycle unless the result path stalls; its result fills the
// stage register and the queue RAM's registered popped-id read, then the output register.
// Reset empties all four queues at once through their counts; no clearing pass is run.
// A stalled result holds in the output register while one more item waits behind it.
// The configuration port is always ready and takes one write per cycle.
module multilevel_feedback_queue_scheduler import mlfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  logic                   command,
    input  logic [ID_W-1:0]        task_id,
    input  logic                   realtime_class,
    input  logic                   finished,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [ID_W-1:0]        dispatched_id,
    output logic [LEVEL_W-1:0]     dispatched_level,
    output logic [SLICE_W-1:0]     slice_length,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SLICE_W-1:0]     cfg_data
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    logic [SLICE_W-1:0] slice_reg [NUM_LEVELS];

    sched_dec_t      dec;
    logic [PtrW-1:0] rd_addr;
    logic [PtrW-1:0] wr_addr;
    logic            accept;
    logic            stage_adv;
    logic            forward;
    logic [ID_W-1:0] ram_rdata [NUM_LEVELS];
    logic [ID_W-1:0] stage_id;
    logic [ID_W-1:0] stage_wdata;

    logic               stage_valid_reg;
    status_t            stage_status_reg;
    level_t             stage_level_reg;
    logic [SLICE_W-1:0] stage_slice_reg;
    logic               stage_pop_reg;
    logic               stage_push_reg;
    level_t             stage_push_level_reg;
    logic [PtrW-1:0]    stage_waddr_reg;
    logic               stage_admit_reg;
    logic [ID_W-1:0]    stage_admit_id_reg;
    logic               stage_fwd_reg;
    logic [ID_W-1:0]    stage_fwd_data_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    level_t             out_level_reg;
    logic [SLICE_W-1:0] out_slice_reg;

    assign cfg_ready = 1'b1;
    assign stage_adv = !out_valid_reg || rsp_ready;
    assign cmd_ready = !stage_valid_reg || stage_adv;
    assign accept    = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg[LVL_REALTIME] <= SLICE_REALTIME_RESET;
            slice_reg[LVL_ONE]      <= SLICE_LEVEL_ONE_RESET;
            slice_reg[LVL_TWO]      <= SLICE_LEVEL_TWO_RESET;
            slice_reg[LVL_THREE]    <= SLICE_LEVEL_THREE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SLICE_REALTIME:    slice_reg[LVL_REALTIME] <= cfg_data;
                REG_SLICE_LEVEL_ONE:   slice_reg[LVL_ONE]      <= cfg_data;
                REG_SLICE_LEVEL_TWO:   slice_reg[LVL_TWO]      <= cfg_data;
                REG_SLICE_LEVEL_THREE: slice_reg[LVL_THREE]    <= cfg_data;
                default:               ;
            endcase
        end
    end

    mlfq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (command),
        .realtime_class (realtime_class),
        .finished       (finished),
        .dec            (dec),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr)
    );

    // All queue writes are issued from the middle stage, so each RAM sees at most one.
    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_queue
        mlfq_ram #(
            .WIDTH(ID_W),
            .DEPTH(QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (stage_valid_reg && stage_adv && stage_push_reg
                    && stage_push_level_reg == level_t'(g)),
            .waddr (stage_waddr_reg),
            .wdata (stage_wdata),
            .re    (accept && dec.pop && dec.level == level_t'(g)),
            .raddr (rd_addr),
            .rdata (ram_rdata[g])
        );
    end

    // A head read that meets the write landing in the same slot takes the written id.
    assign forward = stage_valid_reg && stage_push_reg && dec.pop
                     && stage_push_level_reg == dec.level && stage_waddr_reg == rd_addr;

    assign stage_id    = stage_fwd_reg ? stage_fwd_data_reg : ram_rdata[stage_level_reg];
    assign stage_wdata = stage_admit_reg ? stage_admit_id_reg : stage_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                stage_valid_reg <= cmd_valid;
            end
            if (stage_adv)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_status_reg     <= dec.status;
            stage_level_reg      <= dec.level;
            stage_slice_reg      <= dec.pop ? slice_reg[dec.level] : '0;
            stage_pop_reg        <= dec.pop;
            stage_push_reg       <= dec.push;
            stage_push_level_reg <= dec.push_level;
            stage_waddr_reg      <= wr_addr;
            stage_admit_reg      <= dec.push && !dec.pop;
            stage_admit_id_reg   <= task_id;
            stage_fwd_reg        <= forward;
            stage_fwd_data_reg   <= stage_wdata;
        end
        if (stage_valid_reg && stage_adv)
        begin
            out_status_reg <= stage_status_reg;
            out_id_reg     <= stage_pop_reg ? stage_id : '0;
            out_level_reg  <= stage_level_reg;
            out_slice_reg  <= stage_slice_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign dispatched_id    = out_id_reg;
    assign dispatched_level = out_level_reg;
    assign slice_length     = out_slice_reg;

endmodule

// File: src/mlfq_checker.sv
module mlfq_checker import mlfq_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [STATUS_W-1:0]    status,
    input logic [ID_W-1:0]        dispatched_id,
    input logic [LEVEL_W-1:0]     dispatched_level,
    input logic [SLICE_W-1:0]     slice_length
);

    // A result that is not taken stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(dispatched_id)
            && $stable(dispatched_level) && $stable(slice_length))
    else $error("stalled result changed");

    // An admit result carries no dispatched task.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_ADMITTED || status == ST_REFUSED)
            |-> dispatched_id == '0 && dispatched_level == LVL_REALTIME && slice_length == '0)
    else $error("admit result carries a dispatch");

    // An idle slice reports nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_IDLE
            |-> dispatched_id == '0 && dispatched_level == LVL_REALTIME && slice_length == '0)
    else $error("idle result carries a dispatch");

    // Only defined status codes are reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == ST_ADMITTED || status == ST_REFUSED || status == ST_DISPATCHED
            || status == ST_DROPPED || status == ST_IDLE)
    else $error("undefined status code");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (.*);
